>>> rtl/sfcd_pkg.sv
package sfcd_pkg;

    // frame layout
    localparam logic [7:0] HDR_BYTE    = 8'h0F;
    localparam logic [7:0] FTR_BYTE    = 8'h00;
    localparam int         PAYLOAD_LEN = 22;
    localparam int         FRAME_W     = PAYLOAD_LEN * 8;
    localparam int         NUM_CH      = 16;
    localparam int         CH_W        = 11;
    localparam int         IDX_W       = 4;

    // frame position codes, zero means hunting
    localparam int                 POS_W      = 5;
    localparam logic [POS_W-1:0]   POS_HUNT   = 5'd0;
    localparam logic [POS_W-1:0]   POS_FIRST  = 5'd1;
    localparam logic [POS_W-1:0]   POS_LASTPL = 5'd22;
    localparam logic [POS_W-1:0]   POS_FLAG   = 5'd23;
    localparam logic [POS_W-1:0]   POS_FOOTER = 5'd24;

    // frame queue between decoder front and channel emitter
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [FRAME_W-1:0] t_frame;

    typedef struct packed {
        logic   valid;
        t_frame frame;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

>>> rtl/sfcd_front.sv
module sfcd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_byte,
    output logic               o_ready,
    input  sfcd_pkg::t_q_status i_q_status,
    output sfcd_pkg::t_push    o_push
);

    logic [sfcd_pkg::POS_W-1:0] r_pos;
    logic [sfcd_pkg::POS_W-1:0] n_pos;
    sfcd_pkg::t_frame           r_shift;
    sfcd_pkg::t_frame           n_shift;
    logic                       w_accept;
    logic                       w_good;

    // stall only when a footer would need a full queue
    assign o_ready  = !((r_pos == sfcd_pkg::POS_FOOTER) && i_q_status.full);
    assign w_accept = i_valid && o_ready;
    assign w_good   = (r_pos == sfcd_pkg::POS_FOOTER) && (i_byte == sfcd_pkg::FTR_BYTE);

    // position tracking and payload capture
    always_comb begin
        n_pos   = r_pos;
        n_shift = r_shift;
        if (w_accept) begin
            if (r_pos == sfcd_pkg::POS_HUNT) begin
                if (i_byte == sfcd_pkg::HDR_BYTE) begin
                    n_pos = sfcd_pkg::POS_FIRST;
                end
            end else if (r_pos <= sfcd_pkg::POS_LASTPL) begin
                // newest byte enters at the top, first payload byte ends lowest
                n_shift = {i_byte, r_shift[sfcd_pkg::FRAME_W-1:8]};
                n_pos   = r_pos + 1'b1;
            end else if (r_pos == sfcd_pkg::POS_FLAG) begin
                n_pos = sfcd_pkg::POS_FOOTER;
            end else begin
                n_pos = sfcd_pkg::POS_HUNT;
            end
        end
    end

    // frame handoff on a good footer
    always_comb begin
        o_push.valid = w_accept && w_good;
        o_push.frame = r_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= sfcd_pkg::POS_HUNT;
        end else begin
            r_pos <= n_pos;
        end
        r_shift <= n_shift;
    end

endmodule

>>> rtl/sfcd_queue.sv
module sfcd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sfcd_pkg::t_push     i_push,
    input  logic                i_pop,
    output sfcd_pkg::t_frame    o_head,
    output sfcd_pkg::t_q_status o_status
);

    sfcd_pkg::t_frame            r_mem [sfcd_pkg::QUEUE_DEPTH];
    logic [sfcd_pkg::QPTR_W-1:0] r_wr;
    logic [sfcd_pkg::QPTR_W-1:0] r_rd;
    logic [sfcd_pkg::QCNT_W-1:0] r_cnt;
    logic                        w_wr_en;
    logic                        w_rd_en;

    assign o_status.full  = (r_cnt == sfcd_pkg::QCNT_W'(sfcd_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign w_wr_en        = i_push.valid && !o_status.full;
    assign w_rd_en        = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rd];

    // pointer and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr_en) begin
                r_wr <= (r_wr == sfcd_pkg::QPTR_W'(sfcd_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_rd_en) begin
                r_rd <= (r_rd == sfcd_pkg::QPTR_W'(sfcd_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_wr_en && !w_rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_wr_en && w_rd_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // frame storage
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr] <= i_push.frame;
        end
    end

endmodule

>>> rtl/sfcd_back.sv
module sfcd_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sfcd_pkg::t_frame             i_head,
    input  sfcd_pkg::t_q_status          i_q_status,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [sfcd_pkg::IDX_W-1:0]   o_index,
    output logic [sfcd_pkg::CH_W-1:0]    o_value,
    output logic                         o_last
);

    sfcd_pkg::t_frame           r_work;
    logic                       r_busy;
    logic [sfcd_pkg::IDX_W-1:0] r_ch;
    logic                       r_out_valid;
    logic [sfcd_pkg::IDX_W-1:0] r_out_index;
    logic [sfcd_pkg::CH_W-1:0]  r_out_value;
    logic                       r_out_last;
    logic                       w_adv;
    logic                       w_ch_last;

    assign w_ch_last = (r_ch == sfcd_pkg::IDX_W'(sfcd_pkg::NUM_CH - 1));
    assign w_adv     = r_busy && (!r_out_valid || i_ready);
    assign o_pop     = !r_busy && !i_q_status.empty;

    assign o_valid = r_out_valid;
    assign o_index = r_out_index;
    assign o_value = r_out_value;
    assign o_last  = r_out_last;

    // control: frame load, channel count, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_ch        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_ch   <= '0;
            end else if (w_adv) begin
                r_ch <= r_ch + 1'b1;
                if (w_ch_last) begin
                    r_busy <= 1'b0;
                end
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // channel unpack: lowest 11 bits out, then shift the frame down
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_work <= i_head;
        end else if (w_adv) begin
            r_work <= r_work >> sfcd_pkg::CH_W;
        end
        if (w_adv) begin
            r_out_index <= r_ch;
            r_out_value <= r_work[sfcd_pkg::CH_W-1:0];
            r_out_last  <= w_ch_last;
        end
    end

endmodule

>>> rtl/sbus_frame_channel_decoder_core.sv
// channel   | dir | tdata                     | tuser              | tlast
// s_axis    | in  | [7:0] rx_byte             | -                  | -
// m_axis    | out | [10:0] channel_value      | [3:0] channel_index| last_channel
//
// one input beat per cycle unless stalled; a good frame gives 16 output beats, one per cycle
// while downstream is ready; the first follows the queue write, frame load and output register
// reset (synchronous, active low) returns to header hunt and empties the frame queue
// the input stalls only on a footer beat while the two-entry frame queue is full
// the output register frees the emitter whenever the downstream side takes a beat
module sbus_frame_channel_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [10:0] channel_value, [15:11] zero
    output logic [3:0]  o_m_axis_tuser,   // [3:0] channel_index
    output logic        o_m_axis_tlast    // last_channel
);

    sfcd_pkg::t_push     w_push;
    sfcd_pkg::t_q_status w_q_status;
    sfcd_pkg::t_frame    w_head;
    logic                w_pop;
    logic [sfcd_pkg::CH_W-1:0] w_value;

    // header hunt, payload capture, footer check
    sfcd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .i_byte     (i_s_axis_tdata),
        .o_ready    (o_s_axis_tready),
        .i_q_status (w_q_status),
        .o_push     (w_push)
    );

    // queue of checked frames
    sfcd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    // channel emitter
    sfcd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .i_q_status (w_q_status),
        .o_pop      (w_pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_index    (o_m_axis_tuser),
        .o_value    (w_value),
        .o_last     (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {(16 - sfcd_pkg::CH_W)'(0), w_value};

    // a pushed frame always finds room
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push.valid && w_q_status.full))
        else $error("frame queue overflow");

    // last flag only on the final channel
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tlast == (o_m_axis_tuser == 4'd15)))
        else $error("last flag and channel index disagree");

    // channels of a frame follow each other without gaps
    a_next_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast) |=>
        (o_m_axis_tvalid && (o_m_axis_tuser == $past(o_m_axis_tuser) + 4'd1)))
        else $error("channel sequence broken");

    // a popped frame comes only from a non-empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_status.empty)
        else $error("pop from empty frame queue");

endmodule

>>> test/sbus_frame_channel_decoder_core_tb.sv
module sbus_frame_channel_decoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 24;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_BEATS  = 24;
    localparam int MAX_REPORTS  = 10;

    // one expected output beat
    typedef struct packed {
        logic [sfcd_pkg::IDX_W-1:0] idx;
        logic [sfcd_pkg::CH_W-1:0]  val;
        logic                       last;
    } t_chan_beat;

    // directed stimulus rows
    typedef enum logic [1:0] {
        ROW_NOISE,
        ROW_FLAT,
        ROW_RAMP
    } t_row_kind;

    typedef struct packed {
        t_row_kind                 kind;
        logic [7:0]                seed;
        logic [7:0]                flag;
        logic [7:0]                footer;
        logic                      typed;
        logic [4:0]                exp_cnt;
        logic [sfcd_pkg::CH_W-1:0] exp_val;
    } t_stim_row;

    localparam int NUM_ROWS = 10;

    // typed rows give the channel count and the one value every channel must carry
    t_stim_row dir_rows [NUM_ROWS] = '{
        '{ROW_NOISE, 8'h00, 8'h00, 8'h00, 1'b0, 5'd0,  11'd0},
        '{ROW_NOISE, 8'hFF, 8'h00, 8'h00, 1'b0, 5'd0,  11'd0},
        '{ROW_FLAT,  8'h00, 8'h00, 8'h00, 1'b1, 5'd16, 11'd0},
        '{ROW_FLAT,  8'hFF, 8'hFF, 8'h00, 1'b1, 5'd16, 11'h7FF},
        '{ROW_FLAT,  8'h0F, 8'h0F, 8'h00, 1'b0, 5'd0,  11'd0},
        '{ROW_FLAT,  8'hA5, 8'h00, 8'h0F, 1'b1, 5'd0,  11'd0},
        '{ROW_NOISE, 8'hA5, 8'h00, 8'h00, 1'b0, 5'd0,  11'd0},
        '{ROW_RAMP,  8'h11, 8'h5A, 8'h00, 1'b0, 5'd0,  11'd0},
        '{ROW_FLAT,  8'h5A, 8'h00, 8'h01, 1'b1, 5'd0,  11'd0},
        '{ROW_FLAT,  8'h5A, 8'h00, 8'h80, 1'b1, 5'd0,  11'd0}
    };

    logic             i_clk            = 1'b0;
    logic             i_rst_n          = 1'b0;
    logic             i_s_axis_tvalid  = 1'b0;
    logic [7:0]       i_s_axis_tdata   = 8'h00;
    logic             i_m_axis_tready  = 1'b0;
    logic             o_s_axis_tready;
    logic             o_m_axis_tvalid;
    logic [15:0]      o_m_axis_tdata;
    logic [3:0]       o_m_axis_tuser;
    logic             o_m_axis_tlast;

    // decoder shadow state
    logic [sfcd_pkg::POS_W-1:0] frame_pos = sfcd_pkg::POS_HUNT;
    logic [7:0]                 payload_shadow [sfcd_pkg::PAYLOAD_LEN];
    logic [sfcd_pkg::CH_W-1:0]  decoded_ch [sfcd_pkg::NUM_CH];

    t_chan_beat       pending_channels [$];

    int               src_idle_pct   = 0;
    int               rcv_idle_pct   = 0;
    int               hold_request   = 0;
    int               hold_left      = 0;
    int               cycle_cnt      = 0;
    int               mismatch_cnt   = 0;
    int               counted_beats  = 0;
    int               channels_seen  = 0;
    int               frames_good    = 0;
    int               frames_dropped = 0;

    sbus_frame_channel_decoder_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // advance the shadow decoder by one received byte, fill decoded_ch on a good footer
    task automatic absorb_rx(input logic [7:0] rx, output int n_ch, output bit ignored);
        logic [sfcd_pkg::FRAME_W-1:0] frame_bits;
        n_ch    = 0;
        ignored = 1'b0;
        if (frame_pos == sfcd_pkg::POS_HUNT) begin
            if (rx == sfcd_pkg::HDR_BYTE) begin
                frame_pos = sfcd_pkg::POS_FIRST;
            end else begin
                ignored = 1'b1;
            end
        end else if (frame_pos <= sfcd_pkg::POS_LASTPL) begin
            payload_shadow[frame_pos - sfcd_pkg::POS_FIRST] = rx;
            frame_pos = frame_pos + 1'b1;
        end else if (frame_pos == sfcd_pkg::POS_FLAG) begin
            frame_pos = sfcd_pkg::POS_FOOTER;
        end else begin
            // footer ends the frame either way, and is never a new header
            frame_pos = sfcd_pkg::POS_HUNT;
            if (rx == sfcd_pkg::FTR_BYTE) begin
                for (int i = 0; i < sfcd_pkg::PAYLOAD_LEN; i++) begin
                    frame_bits[8*i +: 8] = payload_shadow[i];
                end
                for (int k = 0; k < sfcd_pkg::NUM_CH; k++) begin
                    decoded_ch[k] = frame_bits[sfcd_pkg::CH_W*k +: sfcd_pkg::CH_W];
                end
                n_ch = sfcd_pkg::NUM_CH;
                frames_good++;
            end else begin
                frames_dropped++;
            end
        end
    endtask

    // offer one byte, wait for the handshake, then queue what it should produce
    task automatic send_byte(input logic [7:0] rx, input bit typed,
                             input int typed_cnt, input logic [sfcd_pkg::CH_W-1:0] typed_val);
        int n_ch;
        bit ignored;
        t_chan_beat beat;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= rx;
        do @(posedge i_clk); while (!o_s_axis_tready);
        absorb_rx(rx, n_ch, ignored);
        if (!ignored) counted_beats++;
        if (typed) n_ch = typed_cnt;
        for (int k = 0; k < n_ch; k++) begin
            beat.idx  = k[sfcd_pkg::IDX_W-1:0];
            beat.val  = typed ? typed_val : decoded_ch[k];
            beat.last = (k == sfcd_pkg::NUM_CH - 1);
            pending_channels.push_back(beat);
        end
    endtask

    // header, payload, flag and footer; only the footer can carry a typed expectation
    task automatic send_frame(input logic [7:0] pl [sfcd_pkg::PAYLOAD_LEN],
                              input logic [7:0] flag,
                              input logic [7:0] footer, input bit typed,
                              input int typed_cnt, input logic [sfcd_pkg::CH_W-1:0] typed_val);
        send_byte(sfcd_pkg::HDR_BYTE, 1'b0, 0, '0);
        for (int i = 0; i < sfcd_pkg::PAYLOAD_LEN; i++) begin
            send_byte(pl[i], 1'b0, 0, '0);
        end
        send_byte(flag, 1'b0, 0, '0);
        send_byte(footer, typed, typed_cnt, typed_val);
    endtask

    // payload bytes lean toward the edge values and the header value
    function automatic logic [7:0] pick_payload_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 8'h00;
        if (r < 20) return 8'hFF;
        if (r < 28) return sfcd_pkg::HDR_BYTE;
        return 8'($urandom);
    endfunction

    task automatic send_random_frame(input logic [7:0] footer);
        logic [7:0] pl [sfcd_pkg::PAYLOAD_LEN];
        for (int i = 0; i < sfcd_pkg::PAYLOAD_LEN; i++) begin
            pl[i] = pick_payload_byte();
        end
        send_frame(pl, pick_payload_byte(), footer, 1'b0, 0, '0);
    endtask

    // mostly good frames, with bad footers, line noise and cut-off frames mixed in
    task automatic send_random_chunk();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            send_random_frame(sfcd_pkg::FTR_BYTE);
        end else if (r < 80) begin
            send_random_frame(8'($urandom_range(1, 255)));
        end else if (r < 90) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) send_byte(8'($urandom), 1'b0, 0, '0);
        end else begin
            n = $urandom_range(1, 20);
            send_byte(sfcd_pkg::HDR_BYTE, 1'b0, 0, '0);
            for (int i = 0; i < n; i++) send_byte(pick_payload_byte(), 1'b0, 0, '0);
        end
    endtask

    // sender goes quiet until every queued channel has come out
    task automatic wait_all_channels();
        i_s_axis_tvalid <= 1'b0;
        while (pending_channels.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_phase(input int src_pct, input int rcv_pct);
        int start;
        src_idle_pct = src_pct;
        rcv_idle_pct = rcv_pct;
        start = counted_beats;
        while (counted_beats - start < PHASE_BEATS) send_random_chunk();
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS) begin
            $display("mismatch %0d at cycle %0d: %s expected 0x%0h got 0x%0h",
                     mismatch_cnt, cycle_cnt, what, exp_v, got_v);
        end
    endtask

    // check one output beat against the oldest expectation
    task automatic check_beat();
        t_chan_beat exp_b;
        channels_seen++;
        if (pending_channels.size() == 0) begin
            note_mismatch("unexpected beat, tdata", 32'h0, 32'(o_m_axis_tdata));
        end else begin
            exp_b = pending_channels.pop_front();
            if (o_m_axis_tdata !== {5'b0, exp_b.val})
                note_mismatch("channel_value", 32'(exp_b.val), 32'(o_m_axis_tdata));
            if (o_m_axis_tuser !== exp_b.idx)
                note_mismatch("channel_index", 32'(exp_b.idx), 32'(o_m_axis_tuser));
            if (o_m_axis_tlast !== exp_b.last)
                note_mismatch("last_channel", 32'(exp_b.last), 32'(o_m_axis_tlast));
        end
    endtask

    // receiver: check accepted beats, drive tready, honor long hold-off requests
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid === 1'b1 && i_m_axis_tready) check_beat();
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    // cycle limit
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d channels still expected",
                 cycle_cnt, pending_channels.size());
        $display("FAILED: results differ");
        $finish;
    end

    // main sequence
    initial begin
        logic [7:0] pl [sfcd_pkg::PAYLOAD_LEN];
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // long receiver hold-off over the directed rows: the first three good frames
        // fill the emitter and the frame queue, so the footer after them, good or bad, stalls the input
        hold_request = HOLD_CYCLES;

        // directed rows, sender idles lightly, receiver heavily
        src_idle_pct = 16;
        rcv_idle_pct = 71;
        for (int r = 0; r < NUM_ROWS; r++) begin
            if (dir_rows[r].kind == ROW_NOISE) begin
                send_byte(dir_rows[r].seed, 1'b0, 0, '0);
            end else begin
                for (int i = 0; i < sfcd_pkg::PAYLOAD_LEN; i++) begin
                    pl[i] = (dir_rows[r].kind == ROW_RAMP) ?
                            dir_rows[r].seed + 8'(i * 37) : dir_rows[r].seed;
                end
                send_frame(pl, dir_rows[r].flag, dir_rows[r].footer, dir_rows[r].typed,
                           int'(dir_rows[r].exp_cnt), dir_rows[r].exp_val);
            end
        end

        random_phase(16, 71);
        wait_all_channels();

        random_phase(71, 16);
        wait_all_channels();

        random_phase(0, 0);
        wait_all_channels();

        $display("sent %0d frame beats plus ignored noise: %0d good frames, %0d dropped",
                 counted_beats, frames_good, frames_dropped);
        $display("checked %0d channel beats, including a %0d-cycle receiver hold-off",
                 channels_seen, HOLD_CYCLES);
        if (mismatch_cnt == 0 && pending_channels.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
